// ===== src/rbd_pkg.sv =====
// shared types, constants and the reciprocal table for the rgb box average downscale unit
// no dependencies; every other file of the block imports this package
package rbd_pkg;

	localparam int CHANNEL_BITS      = 8;
	localparam int MAX_FACTOR        = 16;
	localparam int FACTOR_BITS       = 5;
	localparam int WIDTH_BITS        = 13;
	localparam int WIDTH_LIMIT       = 4096;
	localparam int IN_COL_BITS       = 12;
	localparam int SUM_BITS          = 12;
	localparam int RECIP_SHIFT       = 16;
	localparam int RECIP_BITS        = 17;
	localparam int OUT_COL_BITS      = 9;
	localparam int DEF_MAX_OUT_WIDTH = 512;
	localparam int CFG_ADDR_BITS     = 3;
	localparam int CFG_DATA_BITS     = 32;

	localparam logic [FACTOR_BITS-1:0] FACTOR_RESET = 5'd2;
	localparam logic [WIDTH_BITS-1:0]  WIDTH_RESET  = 13'd800;

	// register index, taken from the address word
	localparam logic REG_SCALE_FACTOR = 1'b0;
	localparam logic REG_IMAGE_WIDTH  = 1'b1;

	typedef logic [CHANNEL_BITS-1:0] chan_t;
	typedef logic [SUM_BITS-1:0]     sum_t;
	typedef logic [RECIP_BITS-1:0]   recip_t;

	typedef struct packed {
		logic [FACTOR_BITS-1:0] factor;
		logic [WIDTH_BITS-1:0]  width;
		recip_t                 recip;
	} cfg_t;

	typedef struct packed {
		logic accept;
		logic divide;
		logic accumulate;
		logic load;
	} dp_cmd_t;

	typedef struct packed {
		logic job;
		logic last_row;
	} dp_sts_t;

	// ceil(2^16 / f): exact floor division for dividends up to 4096
	function automatic recip_t recip_of(input logic [FACTOR_BITS-1:0] f);
		recip_t r;
		case (f)
			5'd1:    r = 17'd65536;
			5'd2:    r = 17'd32768;
			5'd3:    r = 17'd21846;
			5'd4:    r = 17'd16384;
			5'd5:    r = 17'd13108;
			5'd6:    r = 17'd10923;
			5'd7:    r = 17'd9363;
			5'd8:    r = 17'd8192;
			5'd9:    r = 17'd7282;
			5'd10:   r = 17'd6554;
			5'd11:   r = 17'd5958;
			5'd12:   r = 17'd5462;
			5'd13:   r = 17'd5042;
			5'd14:   r = 17'd4682;
			5'd15:   r = 17'd4370;
			5'd16:   r = 17'd4096;
			default: r = 17'd65536;
		endcase
		return r;
	endfunction

endpackage

// ===== src/rbd_regs.sv =====
// configuration registers on the apb port, effective factor and width, shrunk row length
// depends on rbd_pkg
module rbd_regs #(
	parameter int MAX_OUT_WIDTH = rbd_pkg::DEF_MAX_OUT_WIDTH,
	parameter int CW = $clog2(MAX_OUT_WIDTH + 1)
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               psel,
	input  logic                               penable,
	input  logic                               pwrite,
	input  logic [rbd_pkg::CFG_ADDR_BITS-1:0]  paddr,
	input  logic [rbd_pkg::CFG_DATA_BITS-1:0]  pwdata,
	output logic [rbd_pkg::CFG_DATA_BITS-1:0]  prdata,
	output rbd_pkg::cfg_t                      cfg,
	output logic [CW-1:0]                      out_w,
	output logic                               restart,
	output logic                               busy
);
	import rbd_pkg::*;

	logic [FACTOR_BITS-1:0] factor_q;
	logic [WIDTH_BITS-1:0]  width_q;
	logic                   busy_q;
	logic [CW-1:0]          out_w_q;
	logic                   wr;
	logic                   idx;
	logic [FACTOR_BITS-1:0] f_eff;
	logic [WIDTH_BITS-1:0]  w_eff;
	recip_t                 recip;
	logic [WIDTH_BITS+RECIP_BITS-1:0] w_prod;
	logic [WIDTH_BITS-1:0]  w_div;

	assign wr  = psel && penable && pwrite;
	assign idx = paddr[CFG_ADDR_BITS-1];

	always_comb begin
		if (factor_q == '0)
			f_eff = FACTOR_BITS'(1);
		else if (factor_q > FACTOR_BITS'(MAX_FACTOR))
			f_eff = FACTOR_BITS'(MAX_FACTOR);
		else
			f_eff = factor_q;
		if (width_q == '0)
			w_eff = WIDTH_BITS'(1);
		else if (width_q > WIDTH_BITS'(WIDTH_LIMIT))
			w_eff = WIDTH_BITS'(WIDTH_LIMIT);
		else
			w_eff = width_q;
	end

	assign recip  = recip_of(f_eff);
	assign w_prod = {{RECIP_BITS{1'b0}}, w_eff} * {{WIDTH_BITS{1'b0}}, recip};
	assign w_div  = w_prod[RECIP_SHIFT +: WIDTH_BITS];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			factor_q <= FACTOR_RESET;
			width_q  <= WIDTH_RESET;
			busy_q   <= 1'b1;
			out_w_q  <= '0;
		end else begin
			if (wr) begin
				case (idx)
					REG_SCALE_FACTOR: factor_q <= pwdata[FACTOR_BITS-1:0];
					REG_IMAGE_WIDTH:  width_q  <= pwdata[WIDTH_BITS-1:0];
					default:          factor_q <= factor_q;
				endcase
			end
			// shrunk row length reloads while busy is set after a write
			busy_q <= wr;
			if (busy_q) begin
				if (w_div > WIDTH_BITS'(MAX_OUT_WIDTH))
					out_w_q <= CW'(MAX_OUT_WIDTH);
				else
					out_w_q <= CW'(w_div);
			end
		end
	end

	always_comb begin
		case (idx)
			REG_SCALE_FACTOR: prdata = CFG_DATA_BITS'(factor_q);
			REG_IMAGE_WIDTH:  prdata = CFG_DATA_BITS'(width_q);
			default:          prdata = '0;
		endcase
	end

	assign cfg.factor = f_eff;
	assign cfg.width  = w_eff;
	assign cfg.recip  = recip;
	assign out_w      = out_w_q;
	assign restart    = wr;
	assign busy       = busy_q;

endmodule

// ===== src/rbd_ctrl.sv =====
// controller state machine: sequences divide and accumulate for each kept finished group, and
// output load on the last row of a row group; depends on rbd_pkg
module rbd_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	output logic             out_valid,
	input  logic             out_ready,
	input  logic             busy,
	input  rbd_pkg::dp_sts_t sts,
	output rbd_pkg::dp_cmd_t cmd
);
	import rbd_pkg::*;

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_DIV  = 2'd1;
	localparam logic [1:0] ST_ACC  = 2'd2;
	localparam logic [1:0] ST_OUT  = 2'd3;

	logic [1:0] state_q;
	logic [1:0] state_nxt;
	logic       out_valid_q;
	logic       accept;
	logic       out_free;

	assign in_ready = (state_q == ST_IDLE) && !busy;
	assign accept   = in_valid && in_ready;
	assign out_free = !out_valid_q || out_ready;

	always_comb begin
		state_nxt      = state_q;
		cmd.accept     = 1'b0;
		cmd.divide     = 1'b0;
		cmd.accumulate = 1'b0;
		cmd.load       = 1'b0;
		case (state_q)
			ST_IDLE: begin
				cmd.accept = accept;
				if (accept && sts.job)
					state_nxt = ST_DIV;
			end
			ST_DIV: begin
				cmd.divide = 1'b1;
				state_nxt  = ST_ACC;
			end
			ST_ACC: begin
				cmd.accumulate = 1'b1;
				state_nxt      = sts.last_row ? ST_OUT : ST_IDLE;
			end
			ST_OUT: begin
				// wait for the output register to free up
				if (out_free) begin
					cmd.load  = 1'b1;
					state_nxt = ST_IDLE;
				end
			end
			default: state_nxt = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (cmd.load)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
		end
	end

	assign out_valid = out_valid_q;

endmodule

// ===== src/rbd_dp.sv =====
// datapath: group sums, position counters, line store of column sums, reciprocal dividers
// and the output register; depends on rbd_pkg
module rbd_dp #(
	parameter int MAX_OUT_WIDTH = rbd_pkg::DEF_MAX_OUT_WIDTH,
	parameter int CW = $clog2(MAX_OUT_WIDTH + 1),
	parameter int AW = (MAX_OUT_WIDTH > 1) ? $clog2(MAX_OUT_WIDTH) : 1
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  rbd_pkg::cfg_t                     cfg,
	input  logic [CW-1:0]                     out_w,
	input  logic                              restart,
	input  rbd_pkg::dp_cmd_t                  cmd,
	output rbd_pkg::dp_sts_t                  sts,
	input  logic [rbd_pkg::CHANNEL_BITS-1:0]  red_in,
	input  logic [rbd_pkg::CHANNEL_BITS-1:0]  green_in,
	input  logic [rbd_pkg::CHANNEL_BITS-1:0]  blue_in,
	output logic [rbd_pkg::CHANNEL_BITS-1:0]  red_out,
	output logic [rbd_pkg::CHANNEL_BITS-1:0]  green_out,
	output logic [rbd_pkg::CHANNEL_BITS-1:0]  blue_out,
	output logic [rbd_pkg::OUT_COL_BITS-1:0]  out_column,
	output logic                              row_end
);
	import rbd_pkg::*;

	localparam int PROD_BITS = SUM_BITS + RECIP_BITS;

	sum_t                   sum_q [3];
	logic [FACTOR_BITS-1:0] pig_q;
	logic [IN_COL_BITS-1:0] col_in_q;
	logic [CW-1:0]          gc_q;
	logic [FACTOR_BITS-1:0] rows_q;

	sum_t                   work_sum_q [3];
	logic [CW-1:0]          work_col_q;
	logic                   first_q;
	logic                   last_q;
	logic                   end_q;

	logic [3*SUM_BITS-1:0]  mem [MAX_OUT_WIDTH];
	logic [3*SUM_BITS-1:0]  rd_q;
	chan_t                  h_q [3];
	sum_t                   acc_q [3];
	chan_t                  pix_out_q [3];
	logic [OUT_COL_BITS-1:0] out_col_q;
	logic                   out_end_q;

	chan_t                  pix [3];
	sum_t                   sum_add [3];
	sum_t                   acc [3];
	logic [PROD_BITS-1:0]   h_prod [3];
	logic [PROD_BITS-1:0]   o_prod [3];
	logic [FACTOR_BITS-1:0] pig_inc;
	logic [FACTOR_BITS-1:0] rows_inc;
	logic [WIDTH_BITS-1:0]  col_inc;
	logic [CW-1:0]          gc_inc;
	logic                   grp_done;
	logic                   row_done;
	logic                   last_row;
	logic                   job;

	assign pix[0] = red_in;
	assign pix[1] = green_in;
	assign pix[2] = blue_in;

	always_comb begin
		for (int c = 0; c < 3; c++) begin
			sum_add[c] = sum_q[c] + SUM_BITS'(pix[c]);
			h_prod[c]  = {{RECIP_BITS{1'b0}}, work_sum_q[c]} * {{SUM_BITS{1'b0}}, cfg.recip};
			o_prod[c]  = {{RECIP_BITS{1'b0}}, acc_q[c]} * {{SUM_BITS{1'b0}}, cfg.recip};
			if (first_q)
				acc[c] = SUM_BITS'(h_q[c]);
			else
				acc[c] = rd_q[c*SUM_BITS +: SUM_BITS] + SUM_BITS'(h_q[c]);
		end
	end

	assign pig_inc  = pig_q + 1'b1;
	assign rows_inc = rows_q + 1'b1;
	assign col_inc  = {1'b0, col_in_q} + 1'b1;
	assign gc_inc   = gc_q + 1'b1;
	assign grp_done = pig_inc >= cfg.factor;
	assign row_done = col_inc >= cfg.width;
	assign last_row = rows_inc >= cfg.factor;
	// columns beyond the shrunk row are dropped
	assign job      = grp_done && (gc_q < out_w);

	assign sts.job      = job;
	assign sts.last_row = last_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int c = 0; c < 3; c++)
				sum_q[c] <= '0;
			pig_q    <= '0;
			col_in_q <= '0;
			gc_q     <= '0;
			rows_q   <= '0;
		end else if (restart) begin
			for (int c = 0; c < 3; c++)
				sum_q[c] <= '0;
			pig_q    <= '0;
			col_in_q <= '0;
			gc_q     <= '0;
			rows_q   <= '0;
		end else if (cmd.accept) begin
			for (int c = 0; c < 3; c++)
				sum_q[c] <= (grp_done || row_done) ? '0 : sum_add[c];
			pig_q <= (grp_done || row_done) ? '0 : pig_inc;
			if (row_done) begin
				col_in_q <= '0;
				gc_q     <= '0;
				rows_q   <= last_row ? '0 : rows_inc;
			end else begin
				col_in_q <= col_inc[IN_COL_BITS-1:0];
				if (job)
					gc_q <= gc_inc;
			end
		end
	end

	// captured group, worked on after the counters have moved on
	always_ff @(posedge clk) begin
		if (cmd.accept && job) begin
			for (int c = 0; c < 3; c++)
				work_sum_q[c] <= sum_add[c];
			work_col_q <= gc_q;
			first_q    <= (rows_q == '0);
			last_q     <= last_row;
			end_q      <= (gc_inc == out_w);
		end
		if (cmd.divide) begin
			rd_q <= mem[work_col_q[AW-1:0]];
			for (int c = 0; c < 3; c++)
				h_q[c] <= h_prod[c][RECIP_SHIFT +: CHANNEL_BITS];
		end
		if (cmd.accumulate) begin
			mem[work_col_q[AW-1:0]] <= {acc[2], acc[1], acc[0]};
			for (int c = 0; c < 3; c++)
				acc_q[c] <= acc[c];
		end
		if (cmd.load) begin
			for (int c = 0; c < 3; c++)
				pix_out_q[c] <= o_prod[c][RECIP_SHIFT +: CHANNEL_BITS];
			out_col_q <= OUT_COL_BITS'(work_col_q);
			out_end_q <= end_q;
		end
	end

	assign red_out    = pix_out_q[0];
	assign green_out  = pix_out_q[1];
	assign blue_out   = pix_out_q[2];
	assign out_column = out_col_q;
	assign row_end    = out_end_q;

endmodule

// ===== src/rgb_box_average_downscale_unit.sv =====
// a pixel that completes a block raises out_valid once divide, accumulate and output load are done
// one pixel per cycle while idle; a pixel closing a horizontal group in the shrunk row holds input through divide
// and accumulate, on the last row of a row group also through output load (line store read, divide,
// write-back, load), more while the previous output item waits; no pixel is taken the cycle after a register write
// reset: asynchronous, active low; counters and sums clear, factor 2 and width 800 load,
// line store contents are undefined until the first row of a group writes them
module rgb_box_average_downscale_unit #(
	parameter int MAX_OUT_WIDTH = rbd_pkg::DEF_MAX_OUT_WIDTH
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              psel,
	input  logic                              penable,
	input  logic                              pwrite,
	input  logic [rbd_pkg::CFG_ADDR_BITS-1:0] paddr,
	input  logic [rbd_pkg::CFG_DATA_BITS-1:0] pwdata,
	output logic [rbd_pkg::CFG_DATA_BITS-1:0] prdata,
	output logic                              pready,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic [rbd_pkg::CHANNEL_BITS-1:0]  red_in,
	input  logic [rbd_pkg::CHANNEL_BITS-1:0]  green_in,
	input  logic [rbd_pkg::CHANNEL_BITS-1:0]  blue_in,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic [rbd_pkg::CHANNEL_BITS-1:0]  red_out,
	output logic [rbd_pkg::CHANNEL_BITS-1:0]  green_out,
	output logic [rbd_pkg::CHANNEL_BITS-1:0]  blue_out,
	output logic [rbd_pkg::OUT_COL_BITS-1:0]  out_column,
	output logic                              row_end
);
	import rbd_pkg::*;

	localparam int CW = $clog2(MAX_OUT_WIDTH + 1);

	cfg_t          cfg;
	logic [CW-1:0] out_w;
	logic          restart;
	logic          busy;
	dp_cmd_t       cmd;
	dp_sts_t       sts;

	assign pready = 1'b1;

	rbd_regs #(
		.MAX_OUT_WIDTH(MAX_OUT_WIDTH),
		.CW(CW)
	) u_regs (
		.clk(clk),
		.arst_n(arst_n),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.cfg(cfg),
		.out_w(out_w),
		.restart(restart),
		.busy(busy)
	);

	rbd_ctrl u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.busy(busy),
		.sts(sts),
		.cmd(cmd)
	);

	rbd_dp #(
		.MAX_OUT_WIDTH(MAX_OUT_WIDTH),
		.CW(CW)
	) u_dp (
		.clk(clk),
		.arst_n(arst_n),
		.cfg(cfg),
		.out_w(out_w),
		.restart(restart),
		.cmd(cmd),
		.sts(sts),
		.red_in(red_in),
		.green_in(green_in),
		.blue_in(blue_in),
		.red_out(red_out),
		.green_out(green_out),
		.blue_out(blue_out),
		.out_column(out_column),
		.row_end(row_end)
	);

endmodule

// ===== src/rbd_checker.sv =====
// port-level checks on the downscale unit over time, and the bind that attaches them
// depends on rbd_pkg and rgb_box_average_downscale_unit
module rbd_checker (
	input logic                              clk,
	input logic                              arst_n,
	input logic                              psel,
	input logic                              penable,
	input logic                              pwrite,
	input logic                              pready,
	input logic                              in_valid,
	input logic                              in_ready,
	input logic                              out_valid,
	input logic                              out_ready,
	input logic [rbd_pkg::CHANNEL_BITS-1:0]  red_out,
	input logic [rbd_pkg::CHANNEL_BITS-1:0]  green_out,
	input logic [rbd_pkg::CHANNEL_BITS-1:0]  blue_out,
	input logic [rbd_pkg::OUT_COL_BITS-1:0]  out_column,
	input logic                              row_end
);
	import rbd_pkg::*;

	// a waiting output item holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("output item dropped while stalled");

	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable(out_column) && $stable(row_end)
			&& $stable(red_out) && $stable(green_out) && $stable(blue_out))
		else $error("output item changed while stalled");

	// no pixel is taken while the new row length settles
	a_cfg_settle: assert property (@(posedge clk) disable iff (!arst_n)
		psel && penable && pwrite && pready |=> !in_ready)
		else $error("pixel taken right after a register write");

	// a new output item never follows directly on an accepted pixel
	a_out_latency: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> !$past(in_valid && in_ready))
		else $error("output item appeared too early");

endmodule

bind rgb_box_average_downscale_unit rbd_checker u_rbd_checker (.*);
